// ===== src/frustum_plane_extract_defines.svh =====
// Assertion macros shared by the frustum plane extraction RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef FRUSTUM_PLANE_EXTRACT_DEFINES_SVH
`define FRUSTUM_PLANE_EXTRACT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/fpe_pkg.sv =====
// Package for the frustum plane extraction block: widths, step counts and states.
// Depends on nothing; used by frustum_plane_extract.
package fpe_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int ELEM_W      = 32;
	localparam int SUM_W       = ELEM_W + 1;
	localparam int OUT_W       = SUM_W + 1;
	localparam int SQ_W        = 2 * SUM_W;
	localparam int ACC_W       = SQ_W + 1;
	localparam int RAD_W       = ACC_W + (ACC_W % 2);
	localparam int ROOT_W      = RAD_W / 2;
	localparam int REM_W       = ROOT_W + 2;
	localparam int NUM_W       = SUM_W + FRAC_BITS;
	localparam int MIN_LEN_W   = 17;
	localparam int CNT_W       = 6;
	localparam int READ_STEPS  = 8;
	localparam int ROOT_STEPS  = ROOT_W;
	localparam int DIV_STEPS   = NUM_W;

	localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = MIN_LEN_W'(1);
	localparam logic [2:0]           LAST_PLANE    = 3'd5;
	localparam logic [1:0]           COL_OFFSET    = 2'd3;
	localparam logic [1:0]           LAST_COEF     = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SQUARE,
		ST_ROOT,
		ST_CHECK,
		ST_DIVIDE,
		ST_EMIT
	} fpe_state_t;

endpackage

// ===== src/fpe_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module fpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/frustum_plane_extract.sv =====
// Top level of the frustum plane extraction block: matrix store, sequencer,
// square-root and divider datapath. Depends on fpe_pkg, fpe_ram and the defines header.
// A user loads the 16 elements of a 4x4 view-projection matrix (signed Q16.16),
// one per transfer, addressed by row and column; elements persist between
// extractions and read as zero until first written (per-entry valid bits, so no
// clearing pass is needed after reset). A transfer with tlast set stores its
// element and then starts extraction of the six clip planes, emitted in order left,
// right, bottom, top, near, far. Each plane goes through store reads (one RAM read
// port, two elements per row), squaring, bit-serial square root, a threshold check,
// and, if normalized, restoring division of each of the four coefficients, and is
// then handed to the output register. The input is held off during extraction;
// loads are accepted while the last plane still waits in the output register.
`include "frustum_plane_extract_defines.svh"

module frustum_plane_extract (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration: min_length, unsigned Q1.16 length below which a plane is left as is.
	input  logic                              cfg_we,
	input  logic [fpe_pkg::MIN_LEN_W-1:0]     cfg_wdata,
	// Input stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [39:0]                       s_tdata,  // row_index[1:0], col_index[3:2],
	                                                    // element_value[35:4], zero fill
	input  logic                              s_tlast,  // extract_now
	// Output stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [143:0]                      m_tdata,  // plane_index[2:0], coef_a[36:3],
	                                                    // coef_b[70:37], coef_c[104:71],
	                                                    // coef_d[138:105], zero fill
	output logic                              m_tuser,  // normalized
	output logic                              m_tlast   // last_plane
);

	localparam int F  = fpe_pkg::FRAC_BITS;
	localparam int SW = fpe_pkg::SUM_W;
	localparam int OW = fpe_pkg::OUT_W;
	localparam int RW = fpe_pkg::ROOT_W;
	localparam int NW = fpe_pkg::NUM_W;

	// Saturation bounds of the 34-bit output, as magnitudes in quotient width.
	localparam logic [NW-1:0] SAT_POS = NW'((64'd1 << (OW - 1)) - 64'd1);
	localparam logic [NW-1:0] SAT_NEG = NW'(64'd1 << (OW - 1));

	fpe_pkg::fpe_state_t state_q, state_nx;

	logic [fpe_pkg::MIN_LEN_W-1:0] min_len_q;
	logic [fpe_pkg::CNT_W-1:0]     cnt_q;
	logic [2:0]                    plane_q;
	logic [1:0]                    cidx_q;

	// Matrix store, valid bits and read side.
	logic        s_xfer;
	logic [3:0]  ram_raddr;
	logic [31:0] ram_rdata;
	logic [15:0] elem_vld_q;
	logic        rd_vld_s1;
	logic [31:0] rd_elem;

	// Datapath registers.
	logic signed [SW-1:0]          base_q;
	logic signed [SW-1:0]          coef_q [4];
	logic [fpe_pkg::SQ_W-1:0]      sq_s1;
	logic [fpe_pkg::ACC_W-1:0]     acc_q;
	logic [fpe_pkg::RAD_W-1:0]     rad_q;
	logic [fpe_pkg::REM_W-1:0]     srem_q;
	logic [RW-1:0]                 len_q;
	logic                          norm_q;
	logic [NW-1:0]                 num_q;
	logic [NW-1:0]                 quo_q;
	logic [RW-1:0]                 drem_q;
	logic [OW-1:0]                 res_q [4];

	logic                          out_free;
	logic [1:0]                    axis;

	// Output register.
	logic                          m_tvalid_q;
	logic [143:0]                  m_tdata_q;
	logic                          m_tuser_q;
	logic                          m_tlast_q;

	assign s_xfer   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign axis     = plane_q[2:1];

	fpe_ram #(
		.WIDTH (32),
		.DEPTH (16)
	) u_store (
		.clk   (clk),
		.we    (s_xfer),
		.waddr ({s_tdata[1:0], s_tdata[3:2]}),
		.wdata (s_tdata[35:4]),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// An element that was never written reads as zero.
	assign rd_elem = rd_vld_s1 ? ram_rdata : 32'd0;

	// Square-root step: two radicand bits per cycle.
	logic [fpe_pkg::REM_W-1:0] srem_t, strial;
	logic                      sroot_ok;
	assign srem_t   = {srem_q[fpe_pkg::REM_W-3:0], rad_q[fpe_pkg::RAD_W-1 -: 2]};
	assign strial   = {len_q, 2'b01};
	assign sroot_ok = srem_t >= strial;

	// Divider step: one quotient bit per cycle.
	logic [RW:0]  dtrial;
	logic         dfit;
	logic [NW-1:0] quo_nx;
	logic          neg_c;
	logic [OW-1:0] sat_res;
	assign dtrial = {drem_q, num_q[NW-1]};
	assign dfit   = dtrial >= {1'b0, len_q};
	assign quo_nx = {quo_q[NW-2:0], dfit};
	assign neg_c  = coef_q[0][SW-1];

	always_comb begin
		if (neg_c) begin
			sat_res = (quo_nx > SAT_NEG) ? OW'(-SAT_NEG) : OW'(-quo_nx);
		end else begin
			sat_res = (quo_nx > SAT_POS) ? SAT_POS[OW-1:0] : quo_nx[OW-1:0];
		end
	end

	// Magnitude of the coefficient at the head of the rotating bank.
	logic [SW-1:0] mag_c;
	assign mag_c = neg_c ? SW'(-coef_q[0]) : SW'(coef_q[0]);

	// Even read steps fetch m[r][3], odd ones m[r][axis].
	function automatic logic [1:0] COL_OFFSET_SEL(input logic odd, input logic [1:0] ax);
		COL_OFFSET_SEL = odd ? ax : fpe_pkg::COL_OFFSET;
	endfunction

	// Next-state logic.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			fpe_pkg::ST_IDLE: begin
				if (s_xfer && s_tlast) begin
					state_nx = fpe_pkg::ST_READ;
				end
			end
			fpe_pkg::ST_READ: begin
				if (cnt_q == fpe_pkg::CNT_W'(fpe_pkg::READ_STEPS)) begin
					state_nx = fpe_pkg::ST_SQUARE;
				end
			end
			fpe_pkg::ST_SQUARE: begin
				if (cnt_q == fpe_pkg::CNT_W'(3)) begin
					state_nx = fpe_pkg::ST_ROOT;
				end
			end
			fpe_pkg::ST_ROOT: begin
				if (cnt_q == fpe_pkg::CNT_W'(fpe_pkg::ROOT_STEPS - 1)) begin
					state_nx = fpe_pkg::ST_CHECK;
				end
			end
			fpe_pkg::ST_CHECK: begin
				if (len_q != '0 && len_q >= RW'(min_len_q)) begin
					state_nx = fpe_pkg::ST_DIVIDE;
				end else begin
					state_nx = fpe_pkg::ST_EMIT;
				end
			end
			fpe_pkg::ST_DIVIDE: begin
				if (cnt_q == fpe_pkg::CNT_W'(fpe_pkg::DIV_STEPS - 1)
						&& cidx_q == fpe_pkg::LAST_COEF) begin
					state_nx = fpe_pkg::ST_EMIT;
				end
			end
			fpe_pkg::ST_EMIT: begin
				if (out_free) begin
					state_nx = (plane_q == fpe_pkg::LAST_PLANE) ? fpe_pkg::ST_IDLE
						: fpe_pkg::ST_READ;
				end
			end
			default: begin
				state_nx = fpe_pkg::ST_IDLE;
			end
		endcase
	end

	// Output logic: handshake and store read address.
	always_comb begin
		s_tready  = 1'b0;
		ram_raddr = {cnt_q[2:1], COL_OFFSET_SEL(cnt_q[0], axis)};
		case (state_q)
			fpe_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= fpe_pkg::ST_IDLE;
			min_len_q  <= fpe_pkg::MIN_LEN_RESET;
			elem_vld_q <= '0;
			cnt_q      <= '0;
			plane_q    <= '0;
			cidx_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				min_len_q <= cfg_wdata;
			end
			if (s_xfer) begin
				elem_vld_q[{s_tdata[1:0], s_tdata[3:2]}] <= 1'b1;
			end
			// A new plane enters the output register when it is free; otherwise
			// the held plane leaves once the receiver takes it.
			if (state_q == fpe_pkg::ST_EMIT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				fpe_pkg::ST_IDLE: begin
					cnt_q   <= '0;
					plane_q <= '0;
				end
				fpe_pkg::ST_READ, fpe_pkg::ST_SQUARE: begin
					cnt_q <= (state_nx == state_q) ? cnt_q + 1'b1 : '0;
				end
				fpe_pkg::ST_ROOT: begin
					cnt_q <= (state_nx == state_q) ? cnt_q + 1'b1 : '0;
				end
				fpe_pkg::ST_CHECK: begin
					cnt_q  <= '0;
					cidx_q <= '0;
				end
				fpe_pkg::ST_DIVIDE: begin
					if (cnt_q == fpe_pkg::CNT_W'(fpe_pkg::DIV_STEPS - 1)) begin
						cnt_q  <= '0;
						cidx_q <= cidx_q + 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				fpe_pkg::ST_EMIT: begin
					cnt_q <= '0;
					if (out_free) begin
						plane_q <= plane_q + 1'b1;
					end
				end
				default: begin
					cnt_q <= '0;
				end
			endcase
		end
	end

	// Datapath registers carry no reset.
	always_ff @(posedge clk) begin
		rd_vld_s1 <= elem_vld_q[ram_raddr];
		case (state_q)
			fpe_pkg::ST_READ: begin
				if (cnt_q != '0) begin
					if (!cnt_q[0]) begin
						// Data of an odd step arrives on an even count.
						coef_q[cnt_q[2:1] - 2'd1] <= plane_q[0]
							? base_q - SW'(signed'(rd_elem))
							: base_q + SW'(signed'(rd_elem));
					end else begin
						base_q <= SW'(signed'(rd_elem));
					end
				end
				acc_q <= '0;
			end
			fpe_pkg::ST_SQUARE: begin
				// Bank rotates once per cycle and is back in its order when squaring ends.
				coef_q[0] <= coef_q[1];
				coef_q[1] <= coef_q[2];
				coef_q[2] <= coef_q[3];
				coef_q[3] <= coef_q[0];
				sq_s1     <= fpe_pkg::SQ_W'(mag_c) * fpe_pkg::SQ_W'(mag_c);
				if (cnt_q != '0) begin
					acc_q <= acc_q + fpe_pkg::ACC_W'(sq_s1);
				end
				rad_q  <= fpe_pkg::RAD_W'(acc_q + fpe_pkg::ACC_W'(sq_s1));
				srem_q <= '0;
				len_q  <= '0;
			end
			fpe_pkg::ST_ROOT: begin
				rad_q <= {rad_q[fpe_pkg::RAD_W-3:0], 2'b00};
				if (sroot_ok) begin
					srem_q <= srem_t - strial;
					len_q  <= {len_q[RW-2:0], 1'b1};
				end else begin
					srem_q <= srem_t;
					len_q  <= {len_q[RW-2:0], 1'b0};
				end
			end
			fpe_pkg::ST_CHECK: begin
				norm_q <= len_q != '0 && len_q >= RW'(min_len_q);
				num_q  <= {mag_c, F'(0)};
				quo_q  <= '0;
				drem_q <= '0;
				for (int i = 0; i < 4; i++) begin
					res_q[i] <= OW'(coef_q[i]);
				end
			end
			fpe_pkg::ST_DIVIDE: begin
				if (cnt_q == fpe_pkg::CNT_W'(fpe_pkg::DIV_STEPS - 1)) begin
					res_q[0]  <= res_q[1];
					res_q[1]  <= res_q[2];
					res_q[2]  <= res_q[3];
					res_q[3]  <= sat_res;
					coef_q[0] <= coef_q[1];
					coef_q[1] <= coef_q[2];
					coef_q[2] <= coef_q[3];
					coef_q[3] <= coef_q[0];
					num_q     <= {(coef_q[1][SW-1] ? SW'(-coef_q[1]) : SW'(coef_q[1])),
						F'(0)};
					quo_q     <= '0;
					drem_q    <= '0;
				end else begin
					num_q  <= {num_q[NW-2:0], 1'b0};
					quo_q  <= quo_nx;
					drem_q <= dfit ? RW'(dtrial - {1'b0, len_q}) : RW'(dtrial);
				end
			end
			fpe_pkg::ST_EMIT: begin
				if (out_free) begin
					m_tdata_q <= {5'd0, res_q[3], res_q[2], res_q[1], res_q[0], plane_q};
					m_tuser_q <= norm_q;
					m_tlast_q <= plane_q == fpe_pkg::LAST_PLANE;
				end
			end
			default: begin
				acc_q <= '0;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	`FPE_ASSERT_NOW(a_last_is_far, clk, arst_n, m_tvalid && m_tlast,
		m_tdata[2:0] == fpe_pkg::LAST_PLANE, "last plane is not the far plane")
	`FPE_ASSERT_NOW(a_div_len_nonzero, clk, arst_n, state_q == fpe_pkg::ST_DIVIDE,
		len_q != '0, "division by zero length")
	`FPE_ASSERT_NEXT(a_extract_starts, clk, arst_n, s_tvalid && s_tready && s_tlast,
		state_q == fpe_pkg::ST_READ, "extraction did not start")
	`FPE_ASSERT_NOW(a_plane_range, clk, arst_n, state_q != fpe_pkg::ST_IDLE,
		plane_q <= fpe_pkg::LAST_PLANE, "plane counter out of range")

endmodule
